[hw/rtl/sound_register_to_midi_notes_defines.svh]
// Assertion macros shared by the sound register to MIDI note converter.
`ifndef SOUND_REGISTER_TO_MIDI_NOTES_DEFINES_SVH
`define SOUND_REGISTER_TO_MIDI_NOTES_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRMN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRMN_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/srmn_pkg.sv]
// Types, constants and tables of the sound register to MIDI note converter.
package srmn_pkg;

  localparam int unsigned NUM_VOICES = 4;
  localparam int unsigned VOICE_W    = 2;

  // Voice numbers with their own decode.
  localparam logic [VOICE_W-1:0] VOICE_TRIANGLE = 2'd2;
  localparam logic [VOICE_W-1:0] VOICE_NOISE    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TRI_VEL   = 2'd0;
  localparam logic [1:0] CFG_NOISE_VEL = 2'd1;
  localparam logic [1:0] CFG_MUTE      = 2'd2;

  localparam logic [6:0] TRI_VEL_RESET   = 7'd100;
  localparam logic [6:0] NOISE_VEL_RESET = 7'd64;

  // Bus decode.
  localparam logic [15:0] REG_BASE      = 16'h4000;
  localparam logic [15:0] ENABLE_OFFSET = 16'h0015;

  // MIDI status nibbles.
  localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;
  localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;

  // Note mapping: note = NOTE_BASE + number of table entries F with F * (period + 1) <= limit.
  localparam logic [7:0]  NOTE_BASE       = 8'd32;
  localparam logic [6:0]  NOTE_STEPS      = 7'd96;
  localparam logic [25:0] PERIOD_PROD_MAX = 26'd111861;
  localparam logic [7:0]  VOL_SLACK       = 8'd24;
  localparam int unsigned SEARCH_STEPS    = 7;

  localparam logic [6:0] LEN_ROM [32] = '{
    7'd5,  7'd127, 7'd10, 7'd1,  7'd19, 7'd2,  7'd40, 7'd3,
    7'd80, 7'd4,   7'd30, 7'd5,  7'd7,  7'd6,  7'd13, 7'd7,
    7'd6,  7'd8,   7'd12, 7'd9,  7'd24, 7'd10, 7'd48, 7'd11,
    7'd96, 7'd12,  7'd36, 7'd13, 7'd8,  7'd14, 7'd16, 7'd15
  };

  // Smallest quotient giving notes 33 through 128.
  localparam logic [13:0] NOTE_FLOOR [96] = '{
    14'd56, 14'd59, 14'd62,
    14'd66, 14'd70, 14'd74, 14'd78, 14'd83, 14'd88, 14'd93, 14'd99,
    14'd104, 14'd111, 14'd117, 14'd124,
    14'd131, 14'd139, 14'd147, 14'd156, 14'd165, 14'd175, 14'd186, 14'd197,
    14'd208, 14'd221, 14'd234, 14'd247,
    14'd262, 14'd278, 14'd294, 14'd312, 14'd330, 14'd350, 14'd371, 14'd393,
    14'd416, 14'd441, 14'd467, 14'd494,
    14'd524, 14'd555, 14'd588, 14'd623, 14'd660, 14'd699, 14'd741, 14'd785,
    14'd831, 14'd881, 14'd933, 14'd988,
    14'd1047, 14'd1109, 14'd1175, 14'd1245, 14'd1319, 14'd1397, 14'd1481,
    14'd1569, 14'd1662, 14'd1761, 14'd1865, 14'd1976,
    14'd2094, 14'd2218, 14'd2350, 14'd2490, 14'd2638, 14'd2794, 14'd2961,
    14'd3137, 14'd3323, 14'd3521, 14'd3730, 14'd3952,
    14'd4187, 14'd4436, 14'd4699, 14'd4979, 14'd5275, 14'd5588, 14'd5921,
    14'd6273, 14'd6646, 14'd7041, 14'd7459, 14'd7903,
    14'd8373, 14'd8871, 14'd9398, 14'd9957, 14'd10549, 14'd11176, 14'd11841,
    14'd12545, 14'd13291
  };

  typedef struct packed {
    logic        req_type;
    logic [15:0] bus_addr;
    logic [7:0]  bus_data;
  } req_t;

  typedef struct packed {
    logic [7:0] midi_status;
    logic [6:0] note_number;
    logic [6:0] velocity;
    logic       last_msg;
  } msg_t;

  // Controller state, also sent to the datapath as the current phase.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DEFER,
    PH_EVAL,
    PH_SEARCH,
    PH_OFF,
    PH_ON,
    PH_TIMER,
    PH_FLUSH
  } phase_e;

  typedef struct packed {
    phase_e             phase;
    logic [VOICE_W-1:0] voice;
    logic               go;
    logic               wr_en;
  } cmd_t;

  typedef struct packed {
    logic start;
    logic need_emit;
    logic emit_ok;
  } status_t;

endpackage

[hw/rtl/srmn_datapath.sv]
// Datapath: register file, voice state, note search unit and message buffers.
`include "sound_register_to_midi_notes_defines.svh"

module srmn_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  srmn_pkg::cmd_t cmd_i,
  output srmn_pkg::status_t status_o,
  input  srmn_pkg::req_t req_i,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [6:0]     cfg_data_i,
  output srmn_pkg::msg_t msg_o,
  output logic           msg_valid_o,
  input  logic           msg_ready_i
);
  import srmn_pkg::*;

  logic [3:0][7:0] voice_regs_q [NUM_VOICES];
  logic [3:0][7:0] voice_regs_d [NUM_VOICES];
  logic [NUM_VOICES-1:0] enable_q, enable_d;
  logic [NUM_VOICES-1:0] pending_q, pending_d;
  logic [7:0] timer_q [NUM_VOICES];
  logic [7:0] timer_d [NUM_VOICES];
  logic [6:0] play_note_q [NUM_VOICES];
  logic [6:0] play_note_d [NUM_VOICES];
  logic [6:0] play_vel_q [NUM_VOICES];
  logic [6:0] play_vel_d [NUM_VOICES];
  logic [6:0] defer_q [NUM_VOICES];
  logic [6:0] defer_d [NUM_VOICES];

  logic [6:0] tri_vel_q, tri_vel_d;
  logic [6:0] noise_vel_q, noise_vel_d;
  logic       mute_q, mute_d;

  logic [6:0] lo_q, lo_d, hi_q, hi_d;

  logic hold_valid_q, hold_valid_d;
  msg_t hold_q, hold_d;
  logic out_valid_q, out_valid_d;
  msg_t out_q, out_d;

  logic [VOICE_W-1:0] v;
  logic [3:0][7:0]    row;
  logic [6:0]         vol;
  logic [10:0]        period;
  logic [6:0]         len;
  logic               active;
  logic [6:0]         cur_note, cur_vel;
  logic [15:0]        off;

  logic [11:0] fp1;
  logic [7:0]  mid;
  logic [6:0]  probe_idx;
  logic [13:0] probe_floor;
  logic [25:0] prod;
  logic        probe_ok;
  logic [7:0]  note;

  logic defer_fire, off_needed, on_needed, stop_now, out_free;
  logic emit_en;
  msg_t emit_msg;

  assign v        = cmd_i.voice;
  assign row      = voice_regs_q[v];
  assign cur_note = play_note_q[v];
  assign cur_vel  = play_vel_q[v];
  assign len      = LEN_ROM[row[3][7:3]];
  assign off      = req_i.bus_addr - REG_BASE;

  // Voice decode.
  always_comb begin
    case (v)
      VOICE_TRIANGLE: begin
        vol    = tri_vel_q;
        period = {row[3][2:0], row[2]};
      end
      VOICE_NOISE: begin
        vol    = noise_vel_q;
        period = {row[2][3:0], 7'd0};
      end
      default: begin
        vol    = {row[0][3:0], 3'd0};
        period = {row[3][2:0], row[2]};
      end
    endcase
    if (mute_q) begin
      vol = '0;
    end
  end

  assign active = (vol != '0) && (period > 11'd1);

  // One step of the binary search for the note: the answer lies in [lo, hi].
  assign fp1         = {1'b0, period} + 12'd1;
  assign mid         = ({1'b0, lo_q} + {1'b0, hi_q} + 8'd1) >> 1;
  assign probe_idx   = mid[6:0] - 7'd1;
  assign probe_floor = (probe_idx < NOTE_STEPS) ? NOTE_FLOOR[probe_idx] : '0;
  assign prod        = {12'd0, probe_floor} * {14'd0, fp1};
  assign probe_ok    = (prod <= PERIOD_PROD_MAX);
  assign note        = NOTE_BASE + {1'b0, lo_q};

  assign defer_fire = (defer_q[v] != '0) && (defer_q[v] != cur_note);
  assign off_needed = ({1'b0, cur_note} != note)
                   || (({1'b0, vol} + VOL_SLACK) < {1'b0, cur_vel})
                   || (vol > cur_vel)
                   || (vol == '0);
  // A note code of 128 or more never sounds.
  assign on_needed  = !note[7];

  always_comb begin
    stop_now = 1'b0;
    if (cmd_i.go) begin
      case (cmd_i.phase)
        PH_EVAL:  stop_now = !enable_q[v] || !active;
        PH_TIMER: stop_now = (timer_q[v] == 8'd1);
        default:  stop_now = 1'b0;
      endcase
    end
  end

  always_comb begin
    emit_en  = 1'b0;
    emit_msg = '{midi_status: {MIDI_NOTE_OFF, 2'd0, v}, note_number: cur_note,
                 velocity: 7'd0, last_msg: 1'b0};
    case (cmd_i.phase)
      PH_DEFER: begin
        emit_en              = defer_fire;
        emit_msg.note_number = defer_q[v];
      end
      PH_OFF: begin
        emit_en = off_needed;
      end
      PH_ON: begin
        emit_en              = on_needed;
        emit_msg.midi_status = {MIDI_NOTE_ON, 2'd0, v};
        emit_msg.note_number = note[6:0];
        emit_msg.velocity    = vol;
      end
      default: emit_en = 1'b0;
    endcase
  end

  assign out_free = !out_valid_q || msg_ready_i;

  assign status_o.start     = enable_q[v] && active && pending_q[v];
  assign status_o.need_emit = emit_en || ((cmd_i.phase == PH_FLUSH) && hold_valid_q);
  assign status_o.emit_ok   = !hold_valid_q || out_free;

  always_comb begin
    voice_regs_d = voice_regs_q;
    enable_d     = enable_q;
    pending_d    = pending_q;
    timer_d      = timer_q;
    play_note_d  = play_note_q;
    play_vel_d   = play_vel_q;
    defer_d      = defer_q;
    tri_vel_d    = tri_vel_q;
    noise_vel_d  = noise_vel_q;
    mute_d       = mute_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;

    if (out_valid_q && msg_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TRI_VEL:   tri_vel_d   = cfg_data_i;
        CFG_NOISE_VEL: noise_vel_d = cfg_data_i;
        CFG_MUTE:      mute_d      = cfg_data_i[0];
        default:       mute_d      = mute_q;
      endcase
    end

    if (cmd_i.wr_en) begin
      if (off[15:4] == '0) begin
        voice_regs_d[off[3:2]][off[1:0]] = req_i.bus_data;
        pending_d[off[3:2]]              = 1'b1;
      end else if (off == ENABLE_OFFSET) begin
        enable_d = req_i.bus_data[NUM_VOICES-1:0];
      end
    end

    if (cmd_i.go) begin
      case (cmd_i.phase)
        PH_DEFER: begin
          if (defer_fire) begin
            defer_d[v] = '0;
          end
        end
        PH_EVAL: begin
          if (!enable_q[v]) begin
            pending_d[v] = 1'b1;
          end else if (active && pending_q[v]) begin
            pending_d[v] = 1'b0;
            timer_d[v]   = {1'b0, len} + 8'd1;
            lo_d         = '0;
            hi_d         = NOTE_STEPS;
          end
        end
        PH_SEARCH: begin
          if (lo_q < hi_q) begin
            if (probe_ok) begin
              lo_d = mid[6:0];
            end else begin
              hi_d = mid[6:0] - 7'd1;
            end
          end
        end
        PH_OFF: begin
          if (off_needed) begin
            play_note_d[v] = '0;
            play_vel_d[v]  = '0;
          end
        end
        PH_ON: begin
          if (on_needed) begin
            play_note_d[v] = note[6:0];
            play_vel_d[v]  = vol;
          end
        end
        PH_TIMER: begin
          if (timer_q[v] != '0) begin
            timer_d[v] = timer_q[v] - 8'd1;
          end
        end
        PH_FLUSH: begin
          if (hold_valid_q) begin
            out_d          = hold_q;
            out_d.last_msg = 1'b1;
            out_valid_d    = 1'b1;
            hold_valid_d   = 1'b0;
          end
        end
        default: lo_d = lo_q;
      endcase

      // The newest message waits in the hold register so that the last one
      // of a frame can be marked when the frame ends.
      if (emit_en) begin
        if (hold_valid_q) begin
          out_d       = hold_q;
          out_valid_d = 1'b1;
        end
        hold_d       = emit_msg;
        hold_valid_d = 1'b1;
      end

      if (stop_now && (cur_note != '0)) begin
        defer_d[v]     = cur_note;
        play_note_d[v] = '0;
        play_vel_d[v]  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        voice_regs_q[i] <= '0;
        timer_q[i]      <= '0;
        play_note_q[i]  <= '0;
        play_vel_q[i]   <= '0;
        defer_q[i]      <= '0;
      end
      enable_q     <= '0;
      pending_q    <= '0;
      tri_vel_q    <= TRI_VEL_RESET;
      noise_vel_q  <= NOISE_VEL_RESET;
      mute_q       <= 1'b0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      voice_regs_q <= voice_regs_d;
      timer_q      <= timer_d;
      play_note_q  <= play_note_d;
      play_vel_q   <= play_vel_d;
      defer_q      <= defer_d;
      enable_q     <= enable_d;
      pending_q    <= pending_d;
      tri_vel_q    <= tri_vel_d;
      noise_vel_q  <= noise_vel_d;
      mute_q       <= mute_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign msg_o       = out_q;
  assign msg_valid_o = out_valid_q;

  `SRMN_ASSERT_IMP(a_idle_hold_empty, clk_i, rst_ni, cmd_i.phase == PH_IDLE, !hold_valid_q, "message left in hold register while idle")
  `SRMN_ASSERT_NXT(a_flush_marks_last, clk_i, rst_ni, cmd_i.go && (cmd_i.phase == PH_FLUSH) && hold_valid_q, out_valid_q && out_q.last_msg, "final message of a frame not marked last")
  `SRMN_ASSERT_IMP(a_note_vel_pair, clk_i, rst_ni, 1'b1, (play_note_q[v] != '0) == (play_vel_q[v] != '0), "playing note and velocity disagree")

endmodule

[hw/rtl/srmn_ctrl.sv]
// Controller: sequences the deferred note-offs, the per-voice work and the frame end.
module srmn_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_type_i,
  output logic              req_ready_o,
  input  srmn_pkg::status_t status_i,
  output srmn_pkg::cmd_t    cmd_o
);
  import srmn_pkg::*;

  phase_e             state_q, state_d;
  logic [VOICE_W-1:0] voice_q, voice_d;
  logic [2:0]         step_q, step_d;
  logic               advance;

  // A step that sends a message waits until the message buffers can take it.
  assign advance = !status_i.need_emit || status_i.emit_ok;

  always_comb begin
    state_d      = state_q;
    voice_d      = voice_q;
    step_d       = step_q;
    req_ready_o  = 1'b0;
    cmd_o.phase  = state_q;
    cmd_o.voice  = voice_q;
    cmd_o.go     = 1'b0;
    cmd_o.wr_en  = 1'b0;

    case (state_q)
      PH_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.wr_en = req_valid_i && !req_type_i;
        if (req_valid_i && req_type_i) begin
          state_d = PH_DEFER;
          voice_d = '0;
        end
      end
      PH_DEFER: begin
        cmd_o.go = advance;
        if (advance) begin
          voice_d = voice_q + 2'd1;
          if (voice_q == VOICE_W'(NUM_VOICES - 1)) begin
            state_d = PH_EVAL;
          end
        end
      end
      PH_EVAL: begin
        cmd_o.go = 1'b1;
        step_d   = '0;
        state_d  = status_i.start ? PH_SEARCH : PH_TIMER;
      end
      PH_SEARCH: begin
        cmd_o.go = 1'b1;
        step_d   = step_q + 3'd1;
        if (step_q == 3'(SEARCH_STEPS - 1)) begin
          state_d = PH_OFF;
        end
      end
      PH_OFF: begin
        cmd_o.go = advance;
        if (advance) begin
          state_d = PH_ON;
        end
      end
      PH_ON: begin
        cmd_o.go = advance;
        if (advance) begin
          state_d = PH_TIMER;
        end
      end
      PH_TIMER: begin
        cmd_o.go = 1'b1;
        voice_d  = voice_q + 2'd1;
        state_d  = (voice_q == VOICE_W'(NUM_VOICES - 1)) ? PH_FLUSH : PH_EVAL;
      end
      PH_FLUSH: begin
        cmd_o.go = advance;
        if (advance) begin
          state_d = PH_IDLE;
        end
      end
      default: state_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PH_IDLE;
      voice_q <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      voice_q <= voice_d;
      step_q  <= step_d;
    end
  end

endmodule

[hw/rtl/sound_register_to_midi_notes.sv]
// Top level of the sound register to MIDI note converter.
// A register write request is taken while idle and gives no message. A frame
// request sends any deferred note-offs, one voice after another, then works
// through the four voices: it decodes a voice, and for a voice whose note
// restarts runs the binary search of the note table (one table multiply and
// compare a cycle) and sends note-off and note-on where needed, then steps the
// length timer; at the end it releases the last message, which carries
// last_msg. The next request is taken once the frame is done, while its last
// message may still wait in the output register. Configuration writes take
// effect at once.
module sound_register_to_midi_notes (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  srmn_pkg::req_t req_i,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  output srmn_pkg::msg_t msg_o,
  output logic           msg_valid_o,
  input  logic           msg_ready_i,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [6:0]     cfg_data_i
);
  import srmn_pkg::*;

  cmd_t    cmd;
  status_t status;

  srmn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  srmn_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .msg_o       (msg_o),
    .msg_valid_o (msg_valid_o),
    .msg_ready_i (msg_ready_i)
  );

endmodule
